// File: design/nth_root_bisection_macros.svh
// ----------------------------------------------------------------------------
// nth_root_bisection_macros.svh - assertion macros
// Shared property templates for the checker of the n-th root block.
// ----------------------------------------------------------------------------
`ifndef NTH_ROOT_BISECTION_MACROS_SVH
`define NTH_ROOT_BISECTION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NRB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/nrb_pkg.sv
// ----------------------------------------------------------------------------
// nrb_pkg - shared types of the n-th root block
// Command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nrb_pkg;

	// Selects which pair of operand halves goes into the shared multiplier.
	typedef enum logic [1:0] {
		PP_LL = 2'd0,
		PP_HL = 2'd1,
		PP_LH = 2'd2,
		PP_HH = 2'd3
	} pp_sel_t;

	typedef struct packed {
		logic    load;       // capture an input word
		logic    mid_start;  // form the midpoint and reset the power to 1.0
		logic    acc_clr;    // clear the product accumulator
		logic    pp_issue;   // start one partial product
		pp_sel_t pp_sel;
		logic    cmp;        // compare the product and update power or bounds
		logic    out_load;   // move the result into the output register
	} nrb_cmd_t;

	typedef struct packed {
		logic zero_deg;
		logic zero_rad;
		logic search_done;
		logic exceed;
		logic last_deg;
	} nrb_sts_t;

endpackage

`default_nettype wire

// File: design/nrb_ctrl.sv
// ----------------------------------------------------------------------------
// nrb_ctrl - sequencer of the n-th root block
// Steps the bisection loop, the power loop and the partial products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nrb_ctrl
	import nrb_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  wire logic     out_stall,
	input  wire nrb_sts_t sts,
	output nrb_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_STEP,
		S_MUL,
		S_DRAIN,
		S_CMP,
		S_DONE
	} state_t;

	state_t     state_q;
	logic [1:0] pp_idx_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.pp_sel    = pp_sel_t'(pp_idx_q);
		cmd.load      = (state_q == S_IDLE) && in_valid;
		cmd.mid_start = (state_q == S_STEP) && !sts.search_done;
		cmd.pp_issue  = (state_q == S_MUL);
		cmd.acc_clr   = (state_q == S_MUL) && (pp_sel_t'(pp_idx_q) == PP_LL);
		cmd.cmp       = (state_q == S_CMP);
		cmd.out_load  = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pp_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result may replace the one taken at this same edge.
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (sts.zero_deg || sts.zero_rad) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (sts.search_done) begin
						state_q <= S_DONE;
					end else begin
						pp_idx_q <= '0;
						state_q  <= S_MUL;
					end
				end
				S_MUL: begin
					pp_idx_q <= pp_idx_q + 2'd1;
					if (pp_sel_t'(pp_idx_q) == PP_HH) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					pp_idx_q <= '0;
					if (sts.exceed || sts.last_deg) begin
						state_q <= S_STEP;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: design/nrb_dp.sv
// ----------------------------------------------------------------------------
// nrb_dp - datapath of the n-th root block
// Bounds, midpoint, running power, shared multiplier and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nrb_dp
	import nrb_pkg::*;
#(
	parameter int FRAC_BITS     = 16,
	parameter int RADICAND_BITS = 31,
	parameter int MAX_DEGREE    = 15
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire nrb_cmd_t                           cmd,
	output nrb_sts_t                                sts,
	input  wire logic [RADICAND_BITS-1:0]           radicand,
	input  wire logic [3:0]                         degree,
	output logic      [RADICAND_BITS+FRAC_BITS-1:0] root,
	output logic                                    bad_degree
);

	localparam int W     = RADICAND_BITS + FRAC_BITS;
	localparam int H     = (W + 1) / 2;
	localparam int AW    = 2 * W;
	localparam int QW    = AW - FRAC_BITS;
	localparam int DEG_W = $clog2(MAX_DEGREE + 1);
	localparam logic [W-1:0] ONE_FX = W'(1) << FRAC_BITS;
	localparam logic [6:0]   MAXD7  = 7'(MAX_DEGREE);

	logic [W-1:0]     lo_q, hi_q, lim_q, mid_q, pow_q, root_q;
	logic [AW-1:0]    acc_q;
	logic [2*H-1:0]   pp_s1;
	pp_sel_t          pp_sel_s1;
	logic             pp_vld_s1;
	logic [DEG_W-1:0] deg_q, deg_cnt_q;
	logic             zero_rad_q, zero_deg_q, bad_q;

	logic [6:0]       deg7;
	logic [DEG_W-1:0] deg_sat;
	logic [W:0]       bound_sum;
	logic [H-1:0]     op_a, op_b;
	logic [AW-1:0]    pp_ext, pp_shift;
	logic [QW-1:0]    prod_q;
	logic             exceed;

	assign deg7      = 7'(degree);
	assign deg_sat   = (deg7 > MAXD7) ? DEG_W'(MAX_DEGREE) : DEG_W'(deg7);
	assign bound_sum = {1'b0, lo_q} + {1'b0, hi_q};

	always_comb begin
		case (cmd.pp_sel)
			PP_LL: begin
				op_a = pow_q[H-1:0];
				op_b = mid_q[H-1:0];
			end
			PP_HL: begin
				op_a = H'(pow_q[W-1:H]);
				op_b = mid_q[H-1:0];
			end
			PP_LH: begin
				op_a = pow_q[H-1:0];
				op_b = H'(mid_q[W-1:H]);
			end
			default: begin
				op_a = H'(pow_q[W-1:H]);
				op_b = H'(mid_q[W-1:H]);
			end
		endcase
	end

	assign pp_ext = AW'(pp_s1);

	always_comb begin
		case (pp_sel_s1) inside
			PP_LL:        pp_shift = pp_ext;
			PP_HL, PP_LH: pp_shift = pp_ext << H;
			default:      pp_shift = pp_ext << (2 * H);
		endcase
	end

	// Fixed-point product: the full product with the fraction bits dropped.
	assign prod_q = acc_q[AW-1:FRAC_BITS];
	assign exceed = prod_q > QW'(lim_q);

	assign sts.zero_deg    = zero_deg_q;
	assign sts.zero_rad    = zero_rad_q;
	assign sts.search_done = (hi_q <= lo_q) || ((hi_q - lo_q) == W'(1));
	assign sts.exceed      = exceed;
	assign sts.last_deg    = (deg_cnt_q == (deg_q - DEG_W'(1)));

	assign root       = root_q;
	assign bad_degree = bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_vld_s1 <= 1'b0;
		end else begin
			pp_vld_s1 <= cmd.pp_issue;
		end
	end

	always_ff @(posedge clk) begin
		pp_s1     <= op_a * op_b;
		pp_sel_s1 <= cmd.pp_sel;

		if (cmd.load) begin
			lim_q      <= {radicand, FRAC_BITS'(0)};
			hi_q       <= {radicand, FRAC_BITS'(0)};
			lo_q       <= ONE_FX;
			deg_q      <= deg_sat;
			zero_rad_q <= (radicand == '0);
			zero_deg_q <= (degree == 4'd0);
		end

		if (cmd.mid_start) begin
			mid_q     <= bound_sum[W:1];
			pow_q     <= ONE_FX;
			deg_cnt_q <= '0;
		end

		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (pp_vld_s1) begin
			acc_q <= acc_q + pp_shift;
		end

		if (cmd.cmp) begin
			if (exceed) begin
				hi_q <= mid_q;
			end else begin
				pow_q     <= prod_q[W-1:0];
				deg_cnt_q <= deg_cnt_q + DEG_W'(1);
				if (sts.last_deg) begin
					lo_q <= mid_q;
				end
			end
		end

		if (cmd.out_load) begin
			root_q <= (zero_rad_q || zero_deg_q) ? '0 : lo_q;
			bad_q  <= zero_deg_q;
		end
	end

endmodule

`default_nettype wire

// File: design/nth_root_bisection.sv
// ----------------------------------------------------------------------------
// nth_root_bisection - integer n-th root by bisection
// Returns the degree-th root of an integer in unsigned fixed point.
// ----------------------------------------------------------------------------
// The block takes one word at a time: a radicand and a root degree. It returns
// the root with FRAC_BITS fraction bits, found by bisecting between 1.0 and the
// radicand until the bounds are one LSB apart; the lower bound is returned, so
// the result is truncated; for degree one and a radicand above 1.0 it is the
// radicand minus one LSB. A degree of zero gives a root of zero with bad_degree
// set, a radicand of zero gives zero, and degrees above MAX_DEGREE are treated
// as MAX_DEGREE. The time per word depends on the data. Each bisection step
// passes through S_STEP and then, for each multiplication of the running power
// by the midpoint, through S_MUL for four partial products on one shared
// half-width multiplier, S_DRAIN to add the last of them and S_CMP to compare.
// The power loop quits as soon as a partial power passes the radicand, or after
// degree multiplications. About RADICAND_BITS + FRAC_BITS steps are needed for
// large radicands. One word is worked on at a time: in_stall is high from the
// cycle after a word is taken until its result has moved into the output
// register, which waits while an earlier result there is still stalled. The
// next word is then accepted while that result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nth_root_bisection
	import nrb_pkg::*;
#(
	parameter int FRAC_BITS     = 16,
	parameter int RADICAND_BITS = 31,
	parameter int MAX_DEGREE    = 15
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [RADICAND_BITS-1:0]           radicand,
	input  wire logic [3:0]                         degree,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic      [RADICAND_BITS+FRAC_BITS-1:0] root,
	output logic                                    bad_degree
);

	nrb_cmd_t cmd;
	nrb_sts_t sts;

	// The sequencer owns both handshakes; the datapath holds every number.
	nrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	nrb_dp #(
		.FRAC_BITS     (FRAC_BITS),
		.RADICAND_BITS (RADICAND_BITS),
		.MAX_DEGREE    (MAX_DEGREE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.radicand   (radicand),
		.degree     (degree),
		.root       (root),
		.bad_degree (bad_degree)
	);

endmodule

`default_nettype wire

// File: design/nrb_checker.sv
// ----------------------------------------------------------------------------
// nrb_checker - port-level checks of the n-th root block
// Watches the top-level ports and is bound to every instance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "nth_root_bisection_macros.svh"

module nrb_checker #(
	parameter int FRAC_BITS     = 16,
	parameter int RADICAND_BITS = 31
) (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_valid,
	input wire logic                               in_stall,
	input wire logic [RADICAND_BITS-1:0]           radicand,
	input wire logic [3:0]                         degree,
	input wire logic                               out_valid,
	input wire logic                               out_stall,
	input wire logic [RADICAND_BITS+FRAC_BITS-1:0] root,
	input wire logic                               bad_degree
);

	localparam int W = RADICAND_BITS + FRAC_BITS;

	// A flagged degree never carries a root.
	`NRB_ASSERT_NOW(a_bad_deg_zero, clk, arst_n, out_valid && bad_degree, root == '0, "root not zero with bad_degree")

	// Any nonzero root is at least 1.0, the lower bound of the search.
	`NRB_ASSERT_NOW(a_root_min, clk, arst_n, out_valid && (root != '0), root[W-1:FRAC_BITS] != '0, "nonzero root below 1.0")

	// Only one word is in the search at a time.
	`NRB_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && !in_stall, in_stall, "input taken while a search runs")

	// A stalled result stays on the port.
	`NRB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(root) && $stable(bad_degree), "stalled result changed")

	// A stalled input word stays on the port until it is taken.
	`NRB_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && in_stall, in_valid && $stable(radicand) && $stable(degree), "stalled input changed")

endmodule

bind nth_root_bisection nrb_checker #(
	.FRAC_BITS     (FRAC_BITS),
	.RADICAND_BITS (RADICAND_BITS)
) u_nrb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.radicand   (radicand),
	.degree     (degree),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.root       (root),
	.bad_degree (bad_degree)
);

`default_nettype wire
